@@ hdl/e2q_pkg.sv @@
// shared types, constants and arctangent table of the euler to quaternion core
`timescale 1ns / 1ps

package e2q_pkg;

	localparam int ANGLE_W      = 16;
	localparam int Q_W          = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int USED_STEPS   = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int HALF_SHIFT   = 16;
	localparam int XY_W         = 32;
	localparam int Z_W          = 34;
	localparam int PAIR_W       = 33;
	localparam int PROD_W       = 2 * XY_W;
	localparam int PAIR_SHIFT   = 30;
	localparam int TRIPLE_W     = PAIR_W + XY_W;
	localparam int SUM_W        = TRIPLE_W + 1;
	localparam int OUT_SHIFT    = 46;
	localparam int SCALED_W     = SUM_W - OUT_SHIFT;
	localparam int LANES        = 3;
	localparam int LATENCY      = USED_STEPS + 5;

	localparam logic signed [XY_W-1:0]     GAIN_Q30    = XY_W'(64'sd652032874);
	localparam logic signed [Z_W-1:0]      HALF_PI_Q30 = Z_W'(64'sd1686629713);
	localparam logic signed [Z_W-1:0]      PI_Q30      = Z_W'(64'sd3373259426);
	localparam logic signed [PROD_W-1:0]   PAIR_RND    = PROD_W'(64'sd536870912);
	localparam logic signed [SUM_W-1:0]    OUT_RND     = SUM_W'(64'sd35184372088832);
	localparam logic signed [SCALED_W-1:0] Q14_MAX     = SCALED_W'(32'sd16384);
	localparam logic signed [SCALED_W-1:0] Q14_MIN     = SCALED_W'(-32'sd16384);

	localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] yaw_angle;
	} euler_t;

	typedef struct packed {
		logic signed [Q_W-1:0] quat_w;
		logic signed [Q_W-1:0] quat_x;
		logic signed [Q_W-1:0] quat_y;
		logic signed [Q_W-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [XY_W-1:0] sin_r;
		logic signed [XY_W-1:0] cos_r;
		logic signed [XY_W-1:0] sin_p;
		logic signed [XY_W-1:0] cos_p;
		logic signed [XY_W-1:0] sin_y;
		logic signed [XY_W-1:0] cos_y;
	} trig_t;

endpackage

@@ hdl/e2q_cordic.sv @@
// half-angle fold and pipelined sine/cosine cordic, three lanes side by side
`timescale 1ns / 1ps

module e2q_cordic (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  e2q_pkg::euler_t angles,
	output logic           out_valid,
	output e2q_pkg::trig_t trig
);

	logic signed [e2q_pkg::ANGLE_W-1:0] ang [e2q_pkg::LANES];

	logic signed [e2q_pkg::XY_W-1:0] cx_s [0:e2q_pkg::USED_STEPS][e2q_pkg::LANES];
	logic signed [e2q_pkg::XY_W-1:0] cy_s [0:e2q_pkg::USED_STEPS][e2q_pkg::LANES];
	logic signed [e2q_pkg::Z_W-1:0]  cz_s [0:e2q_pkg::USED_STEPS][e2q_pkg::LANES];
	logic                            flip_s [0:e2q_pkg::USED_STEPS][e2q_pkg::LANES];
	logic                            vld_s [0:e2q_pkg::USED_STEPS];

	logic signed [e2q_pkg::XY_W-1:0] sin_o [e2q_pkg::LANES];
	logic signed [e2q_pkg::XY_W-1:0] cos_o [e2q_pkg::LANES];
	logic                            vld_o;

	assign ang[0] = angles.roll_angle;
	assign ang[1] = angles.pitch_angle;
	assign ang[2] = angles.yaw_angle;

	// valid bits follow the data down the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < e2q_pkg::USED_STEPS; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_s[e2q_pkg::USED_STEPS];
		end
	end

	for (genvar l = 0; l < e2q_pkg::LANES; l++) begin : g_lane
		logic signed [e2q_pkg::Z_W-1:0] half;
		logic signed [e2q_pkg::Z_W-1:0] zf;
		logic                           fl;

		// exact half angle, folded into plus or minus pi/2
		always_comb begin
			half = {{(e2q_pkg::Z_W - e2q_pkg::ANGLE_W - e2q_pkg::HALF_SHIFT){ang[l][e2q_pkg::ANGLE_W-1]}},
				ang[l], {e2q_pkg::HALF_SHIFT{1'b0}}};
			zf = half;
			fl = 1'b0;
			if (half > e2q_pkg::HALF_PI_Q30) begin
				zf = e2q_pkg::PI_Q30 - half;
				fl = 1'b1;
			end else if (half < -e2q_pkg::HALF_PI_Q30) begin
				zf = -e2q_pkg::PI_Q30 - half;
				fl = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			cx_s[0][l]   <= e2q_pkg::GAIN_Q30;
			cy_s[0][l]   <= '0;
			cz_s[0][l]   <= zf;
			flip_s[0][l] <= fl;
		end

		for (genvar i = 0; i < e2q_pkg::USED_STEPS; i++) begin : g_step
			localparam logic signed [e2q_pkg::Z_W-1:0] ATAN =
				$signed(e2q_pkg::Z_W'(e2q_pkg::ATAN_Q30[i]));

			always_ff @(posedge clk) begin
				if (!cz_s[i][l][e2q_pkg::Z_W-1]) begin
					cx_s[i+1][l] <= cx_s[i][l] - (cy_s[i][l] >>> i);
					cy_s[i+1][l] <= cy_s[i][l] + (cx_s[i][l] >>> i);
					cz_s[i+1][l] <= cz_s[i][l] - ATAN;
				end else begin
					cx_s[i+1][l] <= cx_s[i][l] + (cy_s[i][l] >>> i);
					cy_s[i+1][l] <= cy_s[i][l] - (cx_s[i][l] >>> i);
					cz_s[i+1][l] <= cz_s[i][l] + ATAN;
				end
				flip_s[i+1][l] <= flip_s[i][l];
			end
		end

		// cosine changes sign for a folded angle
		always_ff @(posedge clk) begin
			sin_o[l] <= cy_s[e2q_pkg::USED_STEPS][l];
			if (flip_s[e2q_pkg::USED_STEPS][l]) begin
				cos_o[l] <= -cx_s[e2q_pkg::USED_STEPS][l];
			end else begin
				cos_o[l] <= cx_s[e2q_pkg::USED_STEPS][l];
			end
		end
	end

	assign out_valid  = vld_o;
	assign trig.sin_r = sin_o[0];
	assign trig.cos_r = cos_o[0];
	assign trig.sin_p = sin_o[1];
	assign trig.cos_p = cos_o[1];
	assign trig.sin_y = sin_o[2];
	assign trig.cos_y = cos_o[2];

endmodule

@@ hdl/e2q_combine.sv @@
// pair products, triple products, rounding and saturation to q1.14
`timescale 1ns / 1ps

module e2q_combine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  e2q_pkg::trig_t trig,
	output logic           out_valid,
	output e2q_pkg::quat_t quat
);

	logic signed [e2q_pkg::PROD_W-1:0]   prod [4];
	logic signed [e2q_pkg::PROD_W-1:0]   prod_rnd [4];
	logic signed [e2q_pkg::PAIR_W-1:0]   pair_s1 [4];
	logic signed [e2q_pkg::XY_W-1:0]     sr_s1;
	logic signed [e2q_pkg::XY_W-1:0]     cr_s1;
	logic                                vld_s1;

	logic signed [e2q_pkg::TRIPLE_W-1:0] trip_s2 [8];
	logic                                vld_s2;

	logic signed [e2q_pkg::SUM_W-1:0]    sum [4];
	logic signed [e2q_pkg::SUM_W-1:0]    sum_rnd [4];
	logic signed [e2q_pkg::SCALED_W-1:0] scaled [4];
	logic signed [e2q_pkg::Q_W-1:0]      sat [4];
	logic signed [e2q_pkg::Q_W-1:0]      q_s3 [4];
	logic                                vld_s3;

	// yaw-pitch pairs: cy*cp, sy*sp, cy*sp, sy*cp
	always_comb begin
		prod[0] = trig.cos_y * trig.cos_p;
		prod[1] = trig.sin_y * trig.sin_p;
		prod[2] = trig.cos_y * trig.sin_p;
		prod[3] = trig.sin_y * trig.cos_p;
		for (int k = 0; k < 4; k++) begin
			prod_rnd[k] = prod[k] + e2q_pkg::PAIR_RND;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			pair_s1[k] <= prod_rnd[k][e2q_pkg::PAIR_SHIFT +: e2q_pkg::PAIR_W];
		end
		sr_s1 <= trig.sin_r;
		cr_s1 <= trig.cos_r;
	end

	always_ff @(posedge clk) begin
		trip_s2[0] <= pair_s1[0] * cr_s1;
		trip_s2[1] <= pair_s1[1] * sr_s1;
		trip_s2[2] <= pair_s1[0] * sr_s1;
		trip_s2[3] <= pair_s1[1] * cr_s1;
		trip_s2[4] <= pair_s1[2] * cr_s1;
		trip_s2[5] <= pair_s1[3] * sr_s1;
		trip_s2[6] <= pair_s1[3] * cr_s1;
		trip_s2[7] <= pair_s1[2] * sr_s1;
	end

	always_comb begin
		sum[0] = trip_s2[0] + trip_s2[1];
		sum[1] = trip_s2[2] - trip_s2[3];
		sum[2] = trip_s2[4] + trip_s2[5];
		sum[3] = trip_s2[6] - trip_s2[7];
		for (int k = 0; k < 4; k++) begin
			sum_rnd[k] = sum[k] + e2q_pkg::OUT_RND;
			scaled[k]  = sum_rnd[k][e2q_pkg::SUM_W-1:e2q_pkg::OUT_SHIFT];
			if (scaled[k] > e2q_pkg::Q14_MAX) begin
				sat[k] = e2q_pkg::Q_W'(e2q_pkg::Q14_MAX);
			end else if (scaled[k] < e2q_pkg::Q14_MIN) begin
				sat[k] = e2q_pkg::Q_W'(e2q_pkg::Q14_MIN);
			end else begin
				sat[k] = scaled[k][e2q_pkg::Q_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			q_s3[k] <= sat[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid   = vld_s3;
	assign quat.quat_w = q_s3[0];
	assign quat.quat_x = q_s3[1];
	assign quat.quat_y = q_s3[2];
	assign quat.quat_z = q_s3[3];

endmodule

@@ hdl/euler_to_quaternion_core.sv @@
// top level: euler angles in, unit quaternion out
`timescale 1ns / 1ps
//
// Converts roll, pitch and yaw (signed Q3.13 radians) into the unit quaternion
// (w, x, y, z) of the yaw-pitch-roll rotation, each part Q1.14 saturated to +-1.
// Input: an angle triple on angles is taken at each rising edge with start high
// and busy low. busy is never raised, so a new triple may come every cycle.
// Output: done is high for exactly one cycle with the quaternion on quat; that
// cycle is the transfer and the receiver cannot hold it off.
// The pipeline holds one fold stage, one stage per cordic step, one sign stage
// for the cosine, then pair product, triple product and rounding stages.
// Throughput is one triple per cycle. Reset clears the valid bits of every
// stage; triples in flight are dropped and no done appears until new ones
// come through.
//
module euler_to_quaternion_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  e2q_pkg::euler_t angles,
	output logic            done,
	output e2q_pkg::quat_t  quat
);

	logic           trig_valid;
	e2q_pkg::trig_t trig;

	assign busy = 1'b0;

	e2q_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.angles    (angles),
		.out_valid (trig_valid),
		.trig      (trig)
	);

	e2q_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (trig_valid),
		.trig      (trig),
		.out_valid (done),
		.quat      (quat)
	);

	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(e2q_pkg::LATENCY) done)
		else $error("transfer in gave no result");

	a_no_phantom : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, e2q_pkg::LATENCY))
		else $error("result without a transfer in");

	a_range : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat.quat_w <= 16'sd16384 && quat.quat_w >= -16'sd16384 &&
			quat.quat_x <= 16'sd16384 && quat.quat_x >= -16'sd16384 &&
			quat.quat_y <= 16'sd16384 && quat.quat_y >= -16'sd16384 &&
			quat.quat_z <= 16'sd16384 && quat.quat_z >= -16'sd16384))
		else $error("quaternion part beyond saturation limit");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench of the euler to quaternion core with its own predictor
`timescale 1ns / 1ps

class quat_scoreboard;
	localparam longint GAIN    = 64'sd652032874;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint PI      = 64'sd3373259426;
	localparam longint Q14_LIM = 64'sd16384;
	localparam int     STEPS   = (e2q_pkg::CORDIC_STEPS < 24) ? e2q_pkg::CORDIC_STEPS : 24;

	longint          atan_tab [24];
	e2q_pkg::quat_t  expected_quats [$];
	int              mismatches;

	function new();
		atan_tab = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
			64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
			64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
			64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
		};
		mismatches = 0;
	endfunction

	// sine and cosine of half the angle, both scaled by 2^30
	function void half_sin_cos(input logic signed [15:0] ang, output longint s,
			output longint c);
		longint a;
		longint x;
		longint y;
		longint nx;
		bit     flip;
		a = longint'(ang) * 64'sd65536;
		x = GAIN;
		y = 0;
		flip = 0;
		if (a > HALF_PI) begin
			a = PI - a;
			flip = 1;
		end else if (a < -HALF_PI) begin
			a = -PI - a;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				a  = a - atan_tab[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				a  = a + atan_tab[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function longint triple_term(input longint a, input longint b, input longint c);
		return ((a * b + 64'sd536870912) >>> 30) * c;
	endfunction

	function logic signed [15:0] round_to_q14(input longint sum60);
		longint v;
		v = (sum60 + 64'sd35184372088832) >>> 46;
		if (v > Q14_LIM)
			v = Q14_LIM;
		if (v < -Q14_LIM)
			v = -Q14_LIM;
		return 16'(v);
	endfunction

	function e2q_pkg::quat_t euler_to_quat(input e2q_pkg::euler_t e);
		e2q_pkg::quat_t q;
		longint sr, cr, sp, cp, sy, cy;
		half_sin_cos(e.roll_angle, sr, cr);
		half_sin_cos(e.pitch_angle, sp, cp);
		half_sin_cos(e.yaw_angle, sy, cy);
		q.quat_w = round_to_q14(triple_term(cy, cp, cr) + triple_term(sy, sp, sr));
		q.quat_x = round_to_q14(triple_term(cy, cp, sr) - triple_term(sy, sp, cr));
		q.quat_y = round_to_q14(triple_term(cy, sp, cr) + triple_term(sy, cp, sr));
		q.quat_z = round_to_q14(triple_term(sy, cp, cr) - triple_term(cy, sp, sr));
		return q;
	endfunction

	task flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task note_angles(input e2q_pkg::euler_t e);
		expected_quats.push_back(euler_to_quat(e));
	endtask

	task check_quat(input e2q_pkg::quat_t got);
		e2q_pkg::quat_t want;
		if (expected_quats.size() == 0) begin
			flag_mismatch($sformatf("unexpected quaternion %h", got));
		end else begin
			want = expected_quats.pop_front();
			if (got.quat_w !== want.quat_w)
				flag_mismatch($sformatf("w got %0d exp %0d", got.quat_w, want.quat_w));
			if (got.quat_x !== want.quat_x)
				flag_mismatch($sformatf("x got %0d exp %0d", got.quat_x, want.quat_x));
			if (got.quat_y !== want.quat_y)
				flag_mismatch($sformatf("y got %0d exp %0d", got.quat_y, want.quat_y));
			if (got.quat_z !== want.quat_z)
				flag_mismatch($sformatf("z got %0d exp %0d", got.quat_z, want.quat_z));
		end
	endtask

	function int pending();
		return expected_quats.size();
	endfunction
endclass

module testbench;
	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	e2q_pkg::euler_t angles;
	logic            done;
	e2q_pkg::quat_t  quat;

	quat_scoreboard sb;
	int             burst_left;

	euler_to_quaternion_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.angles (angles),
		.done   (done),
		.quat   (quat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_angles(angles);
		if (arst_n && done)
			sb.check_quat(quat);
	end

	// holds start high until the transfer
	task send_angles(input e2q_pkg::euler_t e);
		start  <= 1'b1;
		angles <= e;
		do
			@(posedge clk);
		while (busy);
	endtask

	task idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task send_paced(input e2q_pkg::euler_t e);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(5, 30));
			else
				idle_cycles($urandom_range(1, 4));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_angles(e);
	endtask

	function logic signed [15:0] random_angle();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 16'($urandom);
		if (pick == 1)
			return ($urandom_range(0, 1) == 1) ? 16'sd25736 : -16'sd25736;
		return 16'(int'($urandom_range(0, 51472)) - 25736);
	endfunction

	initial begin
		logic signed [15:0] corners [11];
		e2q_pkg::euler_t    e;
		corners = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd25735, -16'sd25735,
			16'sd12868, -16'sd12868, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1};
		sb         = new();
		arst_n     <= 1'b0;
		start      <= 1'b0;
		angles     <= '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner angles rotated over the three axes, then equal triples
		for (int i = 0; i < 11; i++) begin
			e.roll_angle  = corners[i];
			e.pitch_angle = corners[(i + 1) % 11];
			e.yaw_angle   = corners[(i + 2) % 11];
			send_paced(e);
		end
		for (int i = 1; i < 9; i++) begin
			e.roll_angle  = corners[i];
			e.pitch_angle = corners[i];
			e.yaw_angle   = corners[i];
			send_paced(e);
		end

		for (int n = 0; n < 750; n++) begin
			e.roll_angle  = random_angle();
			e.pitch_angle = random_angle();
			e.yaw_angle   = random_angle();
			send_paced(e);
		end
		idle_cycles(1);

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (e2q_pkg::LATENCY + 5) @(posedge clk);

		if (sb.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

@@ euler_to_quaternion_core.f @@
hdl/e2q_pkg.sv
hdl/e2q_cordic.sv
hdl/e2q_combine.sv
hdl/euler_to_quaternion_core.sv
sim/testbench.sv
